// ----- sv/erg_pkg.sv -----
package erg_pkg;

    localparam int STEP_W    = 7;
    localparam int WORD_W    = 64;
    localparam int MAX_STEPS = 64;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic load;
        logic round;
        logic app_on;
        logic app_off;
        logic emit;
    } erg_cmd_t;

    typedef struct packed {
        logic skip;
        logic off_gt1;
        logic on_zero;
        logic off_zero;
    } erg_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_ONES  = 5'b00100,
        ST_ZEROS = 5'b01000,
        ST_EMIT  = 5'b10000
    } erg_state_t;

endpackage

// ----- sv/erg_in_if.sv -----
interface erg_in_if
    import erg_pkg::*;
;
    logic  valid;
    logic  ready;
    step_t step_count;
    step_t pulse_count;

    modport source (output valid, output step_count, output pulse_count, input ready);
    modport sink   (input valid, input step_count, input pulse_count, output ready);
endinterface

// ----- sv/erg_out_if.sv -----
interface erg_out_if
    import erg_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t rhythm_bits;
    logic  bad_request;

    modport source (output valid, output rhythm_bits, output bad_request, input ready);
    modport sink   (input valid, input rhythm_bits, input bad_request, output ready);
endinterface

// ----- sv/erg_ctrl.sv -----
module erg_ctrl
    import erg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  erg_stat_t stat,
    output erg_cmd_t  cmd
);

    erg_state_t state_reg;
    erg_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (stat.skip)
                    state_next = ST_EMIT;
                else if (stat.off_gt1)
                    cmd.round = 1'b1;
                else
                    state_next = ST_ONES;
            end
            ST_ONES:
            begin
                if (stat.on_zero)
                    state_next = ST_ZEROS;
                else
                    cmd.app_on = 1'b1;
            end
            ST_ZEROS:
            begin
                if (stat.off_zero)
                    state_next = ST_EMIT;
                else
                    cmd.app_off = 1'b1;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/erg_datapath.sv -----
module erg_datapath
    import erg_pkg::*;
(
    input  logic      clk,
    input  erg_cmd_t  cmd,
    output erg_stat_t stat,
    input  step_t     step_count,
    input  step_t     pulse_count,
    output word_t     rhythm_bits,
    output logic      bad_request
);

    step_t n_reg;
    step_t on_n_reg;
    step_t off_n_reg;
    step_t on_w_reg;
    step_t off_w_reg;
    word_t on_pat_reg;
    word_t off_pat_reg;
    word_t acc_reg;
    logic  bad_reg;
    logic  skip_reg;
    word_t rhythm_reg;
    logic  bad_out_reg;

    step_t n_clamp;
    logic  ld_bad;
    word_t pair_pat;
    step_t pair_w;
    step_t pairs;
    step_t shift_amt;

    assign n_clamp   = (step_count > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : step_count;
    assign ld_bad    = pulse_count > n_clamp;
    assign pair_pat  = (on_pat_reg << off_w_reg) | off_pat_reg;
    assign pair_w    = on_w_reg + off_w_reg;
    assign pairs     = (on_n_reg < off_n_reg) ? on_n_reg : off_n_reg;
    assign shift_amt = STEP_W'(WORD_W) - n_reg;

    assign stat.skip     = skip_reg;
    assign stat.off_gt1  = off_n_reg > STEP_W'(1);
    assign stat.on_zero  = (on_n_reg == '0);
    assign stat.off_zero = (off_n_reg == '0);

    assign rhythm_bits = rhythm_reg;
    assign bad_request = bad_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg       <= n_clamp;
            on_n_reg    <= pulse_count;
            off_n_reg   <= n_clamp - pulse_count;
            on_w_reg    <= STEP_W'(1);
            off_w_reg   <= STEP_W'(1);
            on_pat_reg  <= WORD_W'(1);
            off_pat_reg <= '0;
            acc_reg     <= '0;
            bad_reg     <= ld_bad;
            skip_reg    <= ld_bad || (pulse_count == '0);
        end
        if (cmd.round)
        begin
            if (on_n_reg > off_n_reg)
            begin
                off_pat_reg <= on_pat_reg;
                off_w_reg   <= on_w_reg;
                off_n_reg   <= on_n_reg - off_n_reg;
            end
            else if (on_n_reg < off_n_reg)
                off_n_reg <= off_n_reg - on_n_reg;
            else
                off_n_reg <= '0;
            on_pat_reg <= pair_pat;
            on_w_reg   <= pair_w;
            on_n_reg   <= pairs;
        end
        if (cmd.app_on)
        begin
            acc_reg  <= (acc_reg << on_w_reg) | on_pat_reg;
            on_n_reg <= on_n_reg - STEP_W'(1);
        end
        if (cmd.app_off)
        begin
            acc_reg   <= (acc_reg << off_w_reg) | off_pat_reg;
            off_n_reg <= off_n_reg - STEP_W'(1);
        end
        if (cmd.emit)
        begin
            rhythm_reg  <= skip_reg ? '0 : (acc_reg << shift_amt);
            bad_out_reg <= bad_reg;
        end
    end

endmodule

// ----- sv/euclidean_rhythm_generator_top.sv -----
// Euclidean rhythm generator: one request beat (step_count, pulse_count) gives one result
// beat with the Bjorklund pattern, step 0 at bit 63 and unused low bits zero; a pulse count
// above the (64-clamped) step count sets bad_request with a zero pattern. One request is
// worked at a time and request.ready is low while it is in flight. Every grouping round
// removes at least one group, so the rounds plus the groups appended never exceed the
// clamped step count. The rounds and the assembly loop each take one step per cycle through
// a 64-bit shifter. The result sits in an output register, so a new request is taken while
// the last result waits.
module euclidean_rhythm_generator_top
    import erg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    erg_in_if.sink    request,
    erg_out_if.source result
);

    erg_cmd_t  cmd;
    erg_stat_t stat;

    erg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    erg_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .step_count  (request.step_count),
        .pulse_count (request.pulse_count),
        .rhythm_bits (result.rhythm_bits),
        .bad_request (result.bad_request)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request taken while busy");

    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.bad_request) |-> (result.rhythm_bits == '0))
        else $error("flagged request with nonzero pattern");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_emit_on_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result.valid || result.ready))
        else $error("result overwritten before taken");
`endif

endmodule

// ----- dv/euclidean_rhythm_generator_top_tb.sv -----
module euclidean_rhythm_generator_top_tb;
    import erg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM   = 750;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_LIMIT = 10;

    localparam word_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam word_t TOP_BIT  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        step_t n;
        step_t k;
        word_t bits;
        logic  bad;
    } rhythm_t;

    typedef struct packed {
        step_t n;
        step_t k;
        logic  known;
        word_t bits;
        logic  bad;
    } rhythm_case_t;

    logic clk;
    logic rst_n;

    erg_in_if  request_ch();
    erg_out_if result_ch();

    euclidean_rhythm_generator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    rhythm_t pending_rhythms [$];
    int      mismatch_count;
    int      stall_cycles;
    bit      hold_sink;

    rhythm_case_t directed_cases [NUM_DIRECTED] = '{
        '{7'd1,   7'd0,   1'b1, 64'd0,                   1'b0},
        '{7'd1,   7'd1,   1'b1, TOP_BIT,                 1'b0},
        '{7'd64,  7'd64,  1'b1, ALL_ONES,                1'b0},
        '{7'd64,  7'd0,   1'b1, 64'd0,                   1'b0},
        '{7'd0,   7'd0,   1'b1, 64'd0,                   1'b0},
        '{7'd0,   7'd1,   1'b1, 64'd0,                   1'b1},
        '{7'd5,   7'd6,   1'b1, 64'd0,                   1'b1},
        '{7'd127, 7'd64,  1'b1, ALL_ONES,                1'b0},
        '{7'd127, 7'd65,  1'b1, 64'd0,                   1'b1},
        '{7'd127, 7'd127, 1'b1, 64'd0,                   1'b1},
        '{7'd65,  7'd0,   1'b1, 64'd0,                   1'b0},
        '{7'd7,   7'd7,   1'b1, 64'hFE00_0000_0000_0000, 1'b0},
        '{7'd64,  7'd1,   1'b1, TOP_BIT,                 1'b0},
        '{7'd8,   7'd3,   1'b0, 64'd0,                   1'b0},
        '{7'd13,  7'd5,   1'b0, 64'd0,                   1'b0},
        '{7'd16,  7'd4,   1'b0, 64'd0,                   1'b0},
        '{7'd64,  7'd63,  1'b0, 64'd0,                   1'b0},
        '{7'd64,  7'd32,  1'b0, 64'd0,                   1'b0},
        '{7'd63,  7'd62,  1'b0, 64'd0,                   1'b0},
        '{7'd2,   7'd1,   1'b0, 64'd0,                   1'b0},
        '{7'd3,   7'd2,   1'b0, 64'd0,                   1'b0},
        '{7'd64,  7'd33,  1'b0, 64'd0,                   1'b0},
        '{7'd100, 7'd37,  1'b0, 64'd0,                   1'b0},
        '{7'd12,  7'd7,   1'b0, 64'd0,                   1'b0},
        '{7'd9,   7'd4,   1'b0, 64'd0,                   1'b0}
    };

    function automatic word_t append_group(word_t head, word_t group, int unsigned width);
        if (width >= WORD_W)
            return group;
        return (head << width) | group;
    endfunction

    function automatic rhythm_t predict_rhythm(step_t n_raw, step_t k_raw);
        rhythm_t     want;
        int unsigned n;
        int unsigned k;
        int unsigned on_n;
        int unsigned off_n;
        int unsigned on_w;
        int unsigned off_w;
        int unsigned pairs;
        int unsigned joined_w;
        word_t       on_pat;
        word_t       off_pat;
        word_t       joined;
        word_t       acc;
        want.n    = n_raw;
        want.k    = k_raw;
        want.bits = '0;
        want.bad  = 1'b0;
        n = n_raw;
        k = k_raw;
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        if (k > n)
        begin
            want.bad = 1'b1;
            return want;
        end
        if (k == 0 || n == 0)
            return want;
        on_pat  = 64'd1;
        off_pat = 64'd0;
        on_w    = 1;
        off_w   = 1;
        on_n    = k;
        off_n   = n - k;
        // groups of one kind are identical, so one copy and a count is enough
        while (off_n > 1)
        begin
            pairs    = (on_n < off_n) ? on_n : off_n;
            joined   = append_group(on_pat, off_pat, off_w);
            joined_w = on_w + off_w;
            if (on_n > off_n)
            begin
                off_pat = on_pat;
                off_w   = on_w;
                off_n   = on_n - off_n;
            end
            else if (on_n < off_n)
                off_n = off_n - on_n;
            else
                off_n = 0;
            on_pat = joined;
            on_w   = joined_w;
            on_n   = pairs;
        end
        acc = '0;
        for (int unsigned i = 0; i < on_n; i++)
            acc = append_group(acc, on_pat, on_w);
        for (int unsigned i = 0; i < off_n; i++)
            acc = append_group(acc, off_pat, off_w);
        want.bits = acc << (WORD_W - n);
        return want;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%t  %s", $realtime, msg);
    endtask

    task automatic send_request(input step_t n, input step_t k, input logic known,
                                input word_t bits, input logic bad);
        rhythm_t want;
        int      gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            request_ch.valid       <= 1'b0;
            request_ch.step_count  <= step_t'($urandom);
            request_ch.pulse_count <= step_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        request_ch.valid       <= 1'b1;
        request_ch.step_count  <= n;
        request_ch.pulse_count <= k;
        do
            @(posedge clk);
        while (!request_ch.ready);
        if (known)
        begin
            want.n    = n;
            want.k    = k;
            want.bits = bits;
            want.bad  = bad;
        end
        else
            want = predict_rhythm(n, k);
        pending_rhythms = {pending_rhythms, want};
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result checking
    always @(posedge clk)
    begin
        rhythm_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_rhythms.size() == 0)
                flag_error($sformatf("result beat with nothing expected: bits %h bad %b",
                                     result_ch.rhythm_bits, result_ch.bad_request));
            else
            begin
                want = pending_rhythms.pop_front();
                if (result_ch.rhythm_bits !== want.bits)
                    flag_error($sformatf("n=%0d k=%0d rhythm_bits expected %h got %h",
                                         want.n, want.k, want.bits, result_ch.rhythm_bits));
                if (result_ch.bad_request !== want.bad)
                    flag_error($sformatf("n=%0d k=%0d bad_request expected %b got %b",
                                         want.n, want.k, want.bad, result_ch.bad_request));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request_ch.valid && request_ch.ready)
                   || (result_ch.valid && result_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side
    initial
    begin
        int run;
        int gap;
        result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_sink = 1'b0;
            end
            else
            begin
                run = $urandom_range(1, 24);
                result_ch.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = idle_gap();
                if (gap > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // request side
    initial
    begin
        step_t n;
        step_t k;
        int    r;
        mismatch_count         = 0;
        stall_cycles           = 0;
        hold_sink              = 1'b0;
        rst_n                  = 1'b0;
        request_ch.valid       = 1'b0;
        request_ch.step_count  = '0;
        request_ch.pulse_count = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
            send_request(directed_cases[i].n, directed_cases[i].k, directed_cases[i].known,
                         directed_cases[i].bits, directed_cases[i].bad);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == 150 || i == 550)
                hold_sink = 1'b1;
            if (i == 350)
            begin
                request_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_rhythms.size() != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 78)
            begin
                n = step_t'($urandom_range(1, MAX_STEPS));
                k = step_t'($urandom_range(0, n));
            end
            else if (r < 84)
            begin
                n = step_t'($urandom_range(1, MAX_STEPS));
                k = ($urandom_range(0, 1) == 0) ? step_t'(0) : n;
            end
            else if (r < 92)
            begin
                n = step_t'($urandom_range(1, MAX_STEPS));
                k = step_t'($urandom_range(n + 1, 127));
            end
            else if (r < 97)
            begin
                n = step_t'($urandom_range(MAX_STEPS + 1, 127));
                k = step_t'($urandom_range(0, 127));
            end
            else
            begin
                n = '0;
                k = ($urandom_range(0, 1) == 0) ? step_t'(0) : step_t'($urandom_range(1, 127));
            end
            send_request(n, k, 1'b0, '0, 1'b0);
        end
        request_ch.valid <= 1'b0;

        while (pending_rhythms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/erg_pkg.sv
sv/erg_in_if.sv
sv/erg_out_if.sv
sv/erg_ctrl.sv
sv/erg_datapath.sv
sv/euclidean_rhythm_generator_top.sv
dv/euclidean_rhythm_generator_top_tb.sv
